// ===== rtl/b64lfe_pkg.sv =====
// Package for the line-framed base64 encoder.
// Holds widths, character codes, the command type passed from front to back,
// and the symbol lookup. No dependencies.
package b64lfe_pkg;

  localparam int POS_W       = 6;
  localparam int CHAR_W      = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [CHAR_W-1:0] CH_S     = 7'h53;
  localparam logic [CHAR_W-1:0] CH_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CH_PAD   = 7'h3D;
  localparam logic [CHAR_W-1:0] CH_NL    = 7'h0A;

  // Character slots of one command, in emission order.
  localparam logic [2:0] SLOT_PRE0 = 3'd0;
  localparam logic [2:0] SLOT_PRE1 = 3'd1;
  localparam logic [2:0] SLOT_PRE2 = 3'd2;
  localparam logic [2:0] SLOT_SYM0 = 3'd3;
  localparam logic [2:0] SLOT_SYM1 = 3'd4;
  localparam logic [2:0] SLOT_SYM2 = 3'd5;
  localparam logic [2:0] SLOT_SYM3 = 3'd6;
  localparam logic [2:0] SLOT_NL   = 3'd7;

  typedef struct packed {
    logic        prefix;     // line prefix comes first
    logic        group;      // four symbols follow
    logic [1:0]  nbytes;     // bytes present in the group, 1 to 3
    logic [23:0] word;       // group bytes, first byte on top
    logic        newline;    // line closes after this byte
    logic        last_line;  // the closing newline ends the stream
  } cmd_t;

  function automatic logic [CHAR_W-1:0] b64_sym(input logic [5:0] v);
    logic [CHAR_W-1:0] r;
    if (v < 6'd26) begin
      r = {1'b0, v} + 7'h41;
    end else if (v < 6'd52) begin
      r = {1'b0, v} + 7'h47;
    end else if (v < 6'd62) begin
      r = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      r = 7'h2B;
    end else begin
      r = 7'h2F;
    end
    return r;
  endfunction

endpackage

// ===== rtl/b64lfe_if.sv =====
// Stream interfaces of the line-framed base64 encoder: byte input and
// character output, each a valid/ready channel. Depends on b64lfe_pkg.
interface b64lfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64lfe_char_if;
  logic                          valid;
  logic                          ready;
  logic [b64lfe_pkg::CHAR_W-1:0] out_char;
  logic                          run_end;
  logic                          stream_end;

  modport source (output valid, output out_char, output run_end, output stream_end,
                  input ready);
  modport sink   (input valid, input out_char, input run_end, input stream_end,
                  output ready);
endinterface

// ===== rtl/b64lfe_front.sv =====
// Front end of the encoder: takes bytes, tracks the line position and the
// open group, and issues one command per byte that produces text.
// Depends on b64lfe_pkg and b64lfe_if.
module b64lfe_front #(
  parameter int BYTES_PER_LINE = 54
) (
  input  logic               clk,
  input  logic               rst,
  b64lfe_byte_if.sink        in_bytes,
  input  logic               q_full,
  output logic               push,
  output b64lfe_pkg::cmd_t   push_cmd
);

  localparam logic [b64lfe_pkg::POS_W-1:0] LINE_LEN = b64lfe_pkg::POS_W'(BYTES_PER_LINE);

  logic [b64lfe_pkg::POS_W-1:0] pos;
  logic [b64lfe_pkg::POS_W-1:0] pos_inc;
  logic [1:0]                   grp;
  logic [15:0]                  held;
  logic                         accept;
  logic                         line_done;
  logic [23:0]                  word;

  assign in_bytes.ready = !rst && !q_full;
  assign accept         = in_bytes.valid && in_bytes.ready;
  assign pos_inc        = pos + 1'b1;
  assign line_done      = in_bytes.final_byte || (pos_inc >= LINE_LEN);

  always_comb begin
    case (grp)
      2'd0:    word = {in_bytes.data_byte, 16'h0000};
      2'd1:    word = {held[15:8], in_bytes.data_byte, 8'h00};
      default: word = {held, in_bytes.data_byte};
    endcase
  end

  assign push = accept && ((pos == '0) || (grp == 2'd2) || line_done);

  always_comb begin
    push_cmd.prefix    = (pos == '0);
    push_cmd.group     = (grp == 2'd2) || line_done;
    push_cmd.nbytes    = grp + 2'd1;
    push_cmd.word      = word;
    push_cmd.newline   = line_done;
    push_cmd.last_line = in_bytes.final_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      grp  <= '0;
      held <= '0;
    end else if (accept) begin
      if (line_done) begin
        pos  <= '0;
        grp  <= '0;
        held <= '0;
      end else begin
        pos <= pos_inc;
        case (grp)
          2'd0: begin
            grp  <= 2'd1;
            held <= {in_bytes.data_byte, 8'h00};
          end
          2'd1: begin
            grp  <= 2'd2;
            held <= {held[15:8], in_bytes.data_byte};
          end
          default: begin
            grp  <= 2'd0;
            held <= '0;
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/b64lfe_queue.sv =====
// Command queue between the front and back ends of the encoder.
// Small register file with read and write pointers. Depends on b64lfe_pkg.
module b64lfe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64lfe_pkg::cmd_t push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output b64lfe_pkg::cmd_t head_cmd
);

  b64lfe_pkg::cmd_t                mem [b64lfe_pkg::QUEUE_DEPTH];
  logic [b64lfe_pkg::QPTR_W-1:0]   wr_ptr;
  logic [b64lfe_pkg::QPTR_W-1:0]   rd_ptr;
  logic [b64lfe_pkg::QPTR_W:0]     count;

  assign full       = (count == (b64lfe_pkg::QPTR_W+1)'(b64lfe_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/b64lfe_back.sv =====
// Back end of the encoder: walks the head command's characters, one per cycle
// unless stalled, into a registered output stage; uses b64lfe_pkg, b64lfe_if.
module b64lfe_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  b64lfe_pkg::cmd_t head_cmd,
  output logic             pop,
  b64lfe_char_if.source    out_chars
);

  logic [7:0]                    present;
  logic [7:0]                    above;
  logic [2:0]                    slot;
  logic                          started;
  logic [2:0]                    cur;
  logic [2:0]                    first;
  logic [2:0]                    nxt;
  logic                          last;
  logic                          load;
  logic                          out_valid;
  logic [b64lfe_pkg::CHAR_W-1:0] ch;

  assign present = {head_cmd.newline, {4{head_cmd.group}}, {3{head_cmd.prefix}}};

  // Lowest present slot of a fresh command.
  always_comb begin
    first = b64lfe_pkg::SLOT_NL;
    for (int i = 7; i >= 0; i--) begin
      if (present[i]) begin
        first = 3'(i);
      end
    end
  end

  assign cur = started ? slot : first;

  always_comb begin
    nxt = b64lfe_pkg::SLOT_NL;
    for (int i = 7; i >= 0; i--) begin
      above[i] = present[i] && (3'(i) > cur);
      if (above[i]) begin
        nxt = 3'(i);
      end
    end
  end

  assign last = (above == '0);

  always_comb begin
    case (cur)
      b64lfe_pkg::SLOT_PRE0: ch = b64lfe_pkg::CH_S;
      b64lfe_pkg::SLOT_PRE1: ch = b64lfe_pkg::CH_S;
      b64lfe_pkg::SLOT_PRE2: ch = b64lfe_pkg::CH_COLON;
      b64lfe_pkg::SLOT_SYM0: ch = b64lfe_pkg::b64_sym(head_cmd.word[23:18]);
      b64lfe_pkg::SLOT_SYM1: ch = b64lfe_pkg::b64_sym(head_cmd.word[17:12]);
      b64lfe_pkg::SLOT_SYM2: ch = (head_cmd.nbytes > 2'd1) ?
                                  b64lfe_pkg::b64_sym(head_cmd.word[11:6]) :
                                  b64lfe_pkg::CH_PAD;
      b64lfe_pkg::SLOT_SYM3: ch = (head_cmd.nbytes > 2'd2) ?
                                  b64lfe_pkg::b64_sym(head_cmd.word[5:0]) :
                                  b64lfe_pkg::CH_PAD;
      default:               ch = b64lfe_pkg::CH_NL;
    endcase
  end

  assign load            = head_valid && (!out_valid || out_chars.ready);
  assign pop             = load && last;
  assign out_chars.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      started   <= 1'b0;
      slot      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        started   <= !last;
        slot      <= nxt;
      end else if (out_chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_chars.out_char   <= ch;
      out_chars.run_end    <= last;
      out_chars.stream_end <= (cur == b64lfe_pkg::SLOT_NL) && head_cmd.last_line;
    end
  end

endmodule

// ===== rtl/base64_line_framed_encoder_core.sv =====
// Top level of the line-framed base64 encoder: front end, command queue and
// back end. Depends on b64lfe_pkg, b64lfe_if and the three submodules.
//
//   channel    direction  payload                             transfer when
//   in_bytes   in         data_byte[7:0], final_byte          valid && ready
//   out_chars  out        out_char[6:0], run_end, stream_end  valid && ready
//
// The back end emits one character per cycle, unless out_chars stalls, from
// a registered output stage; a full line of 54 bytes yields 76 characters.
// The front end takes a byte in every cycle while the four-entry command
// queue has room; bytes that only fill an open group take no queue entry.
// Reset (rst, synchronous) clears the line position, the held group bytes,
// the queue and the output stage; the block is ready the cycle after.
// A stall on out_chars holds the current character and fills the queue,
// after which in_bytes.ready drops until a command drains.
module base64_line_framed_encoder_core #(
  parameter int BYTES_PER_LINE = 54
) (
  input  logic          clk,
  input  logic          rst,
  b64lfe_byte_if.sink   in_bytes,
  b64lfe_char_if.source out_chars
);

  logic             push;
  logic             pop;
  logic             q_full;
  logic             head_valid;
  b64lfe_pkg::cmd_t push_cmd;
  b64lfe_pkg::cmd_t head_cmd;

  // Front end: classifies each byte into prefix, group and newline work.
  b64lfe_front #(
    .BYTES_PER_LINE(BYTES_PER_LINE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_bytes (in_bytes),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decoupling queue so that either side can stall on its own.
  b64lfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: serializes each command into characters.
  b64lfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_chars  (out_chars)
  );

endmodule

// ===== rtl/b64lfe_checker.sv =====
// Port-level checks for the line-framed base64 encoder, and the bind that
// attaches them to base64_line_framed_encoder_core. Depends on b64lfe_pkg.
module b64lfe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [b64lfe_pkg::CHAR_W-1:0] out_char,
  input logic                          run_end,
  input logic                          stream_end
);

  // A stalled character holds until its transfer.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(run_end)
                                && $stable(stream_end))
    else $error("output changed while stalled");

  // The end of the stream is always a newline that closes its byte's run.
  a_stream_end_nl: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> (out_char == b64lfe_pkg::CH_NL) && run_end)
    else $error("stream end not on a closing newline");

  // A newline is always the last character of its byte's run.
  a_newline_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_char == b64lfe_pkg::CH_NL) |-> run_end)
    else $error("newline not at the end of its run");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind base64_line_framed_encoder_core b64lfe_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_chars.valid),
  .out_ready  (out_chars.ready),
  .out_char   (out_chars.out_char),
  .run_end    (out_chars.run_end),
  .stream_end (out_chars.stream_end)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for base64_line_framed_encoder_core.
// Depends on b64lfe_pkg, the b64lfe_byte_if/b64lfe_char_if interfaces and the core RTL.
module testbench;

  // Line length used for the block under test and for the local encoder model.
  localparam int LINE_BYTES = 54;
  // Run limit in clock cycles. The run sends about 180 bytes; even with each one
  // causing eight characters, each waiting out the longest output stall, plus the
  // long sender gaps, the run stays well inside this limit.
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_BYTES = 50;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 20;

  // One expected character transfer on the output channel.
  typedef struct packed {
    logic [b64lfe_pkg::CHAR_W-1:0] ch;
    logic                          run_end;
    logic                          stream_end;
  } char_xfer_t;

  // One row of the directed table. A row with reps above one sends that many
  // random bytes, and only the last of them carries the row's final flag.
  // Rows with typed set carry the exact characters they must produce.
  typedef struct {
    logic [7:0] data;
    logic       fin;
    int         reps;
    bit         typed;
    string      text;
  } byte_row_t;

  localparam string B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic clk;
  logic rst;

  b64lfe_byte_if in_bytes ();
  b64lfe_char_if out_chars ();

  base64_line_framed_encoder_core #(
    .BYTES_PER_LINE(LINE_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_bytes (in_bytes),
    .out_chars(out_chars)
  );

  // Encoder model state: bytes taken into the current line, and the first
  // one or two bytes of the open group (first byte in the upper half).
  logic [b64lfe_pkg::POS_W-1:0] line_pos;
  logic [15:0]                  group_bytes;

  char_xfer_t step_chars[$];    // characters caused by the byte being predicted
  char_xfer_t pending_chars[$]; // characters still owed by the block, oldest first

  int mismatches;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and run limit. Running out of cycles means characters went
  // missing or the block hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycles,
               pending_chars.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // ASCII code of one symbol of the alphabet.
  function automatic logic [b64lfe_pkg::CHAR_W-1:0] alpha_char(input logic [5:0] v);
    byte c;
    c = B64_ALPHABET[v];
    return c[b64lfe_pkg::CHAR_W-1:0];
  endfunction

  function automatic void add_char(input logic [b64lfe_pkg::CHAR_W-1:0] ch,
                                   input logic stream_end);
    step_chars.push_back('{ch: ch, run_end: 1'b0, stream_end: stream_end});
  endfunction

  // Four characters for a group. Missing bytes of a short group turn into pad
  // characters, so a one-byte group ends in two pads and a two-byte group in one.
  function automatic void add_group(input logic [23:0] word, input int nbytes);
    add_char(alpha_char(word[23:18]), 1'b0);
    add_char(alpha_char(word[17:12]), 1'b0);
    add_char(nbytes > 1 ? alpha_char(word[11:6]) : b64lfe_pkg::CH_PAD, 1'b0);
    add_char(nbytes > 2 ? alpha_char(word[5:0]) : b64lfe_pkg::CH_PAD, 1'b0);
  endfunction

  // Advances the encoder model by one byte and leaves the characters that this
  // byte causes in step_chars. The list may be empty.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    int  pos;
    int  slot;
    bit  line_done;
    pos = line_pos;
    step_chars.delete();
    if (pos >= LINE_BYTES) pos = 0;
    slot = pos % 3;

    // The first byte of a line is preceded by the line prefix.
    if (pos == 0) begin
      add_char(b64lfe_pkg::CH_S, 1'b0);
      add_char(b64lfe_pkg::CH_S, 1'b0);
      add_char(b64lfe_pkg::CH_COLON, 1'b0);
    end

    if (slot == 0) begin
      group_bytes = {b, 8'h00};
    end else if (slot == 1) begin
      group_bytes[7:0] = b;
    end

    pos++;
    line_done = fin || pos >= LINE_BYTES;

    // A third byte completes its group. Otherwise the open group is flushed
    // with padding only when the line closes, either because it is full or
    // because the payload ends.
    if (slot == 2) begin
      add_group({group_bytes, b}, 3);
      group_bytes = '0;
    end else if (line_done) begin
      add_group({group_bytes, 8'h00}, slot + 1);
      group_bytes = '0;
    end

    if (line_done) begin
      add_char(b64lfe_pkg::CH_NL, fin);
      pos = 0;
    end
    line_pos = pos[b64lfe_pkg::POS_W-1:0];

    if (step_chars.size() > 0) begin
      step_chars[step_chars.size()-1].run_end = 1'b1;
    end
  endfunction

  // Drives one byte from the falling edge and holds it until the rising edge
  // at which the transfer happens. The expectation is queued at that edge.
  // A typed row replaces the model's characters by the listed ones, but the
  // model still steps so that its line position stays in line with the block.
  task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
                           input string text);
    byte c;
    @(negedge clk);
    in_bytes.valid      <= 1'b1;
    in_bytes.data_byte  <= b;
    in_bytes.final_byte <= fin;
    do @(posedge clk); while (!in_bytes.ready);
    encode_byte(b, fin);
    if (typed) begin
      for (int i = 0; i < text.len(); i++) begin
        c = text[i];
        pending_chars.push_back('{ch: c[b64lfe_pkg::CHAR_W-1:0],
                                  run_end: i == text.len() - 1,
                                  stream_end: (i == text.len() - 1) && fin});
      end
    end else begin
      foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
    end
  endtask

  // Drops valid for a gap between sends. Each cycle of the gap is one falling edge, so
  // the next send raises valid at a later edge than the one that lowered it.
  task automatic idle_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_bytes.valid     <= 1'b0;
      in_bytes.data_byte <= 8'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Mostly no gap, sometimes a short one, and now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Output side: bursts of ready with random stalls between them. A few stalls
  // are long enough to fill the command queue, and some bursts run back to back
  // with no stall at all.
  initial begin
    int burst;
    int stall;
    int roll;
    out_chars.ready <= 1'b0;
    forever begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      @(negedge clk);
      out_chars.ready <= 1'b1;
      repeat (burst - 1) @(negedge clk);
      roll = $urandom_range(0, 99);
      if (roll < 25) stall = 0;
      else if (roll < 93) stall = $urandom_range(1, 3);
      else stall = $urandom_range(20, 60);
      if (stall > 0) begin
        @(negedge clk);
        out_chars.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // Output check. Every character transfer is compared field by field with the
  // oldest expectation. A transfer with nothing expected is a failure too.
  always @(posedge clk) begin
    char_xfer_t want;
    if (!rst && out_chars.valid && out_chars.ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h run_end=%b stream_end=%b",
                                  out_chars.out_char, out_chars.run_end,
                                  out_chars.stream_end));
      end else begin
        want = pending_chars.pop_front();
        if (out_chars.out_char !== want.ch || out_chars.run_end !== want.run_end ||
            out_chars.stream_end !== want.stream_end) begin
          report_mismatch($sformatf(
              "expected char 0x%02h run_end=%b stream_end=%b, got 0x%02h %b %b",
              want.ch, want.run_end, want.stream_end, out_chars.out_char,
              out_chars.run_end, out_chars.stream_end));
        end
      end
    end
  end

  // Directed rows: zero and all-ones bytes as one-byte payloads, bytes that
  // are only held in an open group, short final groups of one and two bytes,
  // a complete group, a full line closed by its length alone, and a payload
  // that carries on into a second line.
  byte_row_t directed_rows[] = '{
    '{8'h00, 1'b1, 1,  1'b1, "SS:AA==\n"},
    '{8'hFF, 1'b1, 1,  1'b1, "SS:/w==\n"},
    '{8'hFF, 1'b0, 1,  1'b1, "SS:"},
    '{8'hFF, 1'b1, 1,  1'b1, "//8=\n"},
    '{8'h00, 1'b0, 1,  1'b1, "SS:"},
    '{8'h00, 1'b0, 1,  1'b1, ""},
    '{8'h00, 1'b1, 1,  1'b1, "AAAA\n"},
    '{8'hFF, 1'b0, 1,  1'b1, "SS:"},
    '{8'hFF, 1'b0, 1,  1'b1, ""},
    '{8'hFF, 1'b0, 1,  1'b1, "////"},
    '{8'h80, 1'b1, 1,  1'b1, "gA==\n"},
    '{8'h01, 1'b0, 1,  1'b0, ""},
    '{8'h00, 1'b0, 53, 1'b0, ""},
    '{8'h7F, 1'b0, 1,  1'b0, ""},
    '{8'hFE, 1'b1, 1,  1'b0, ""},
    '{8'h55, 1'b0, 1,  1'b0, ""},
    '{8'hAA, 1'b0, 1,  1'b0, ""},
    '{8'h00, 1'b1, 60, 1'b0, ""}
  };

  initial begin
    int         sent;
    int         len;
    int         roll;
    bit         gaps_on;
    logic [7:0] b;

    line_pos    = '0;
    group_bytes = '0;

    in_bytes.valid      <= 1'b0;
    in_bytes.data_byte  <= 8'h00;
    in_bytes.final_byte <= 1'b0;

    // Synchronous reset, released at a falling edge.
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        b = (directed_rows[r].reps > 1) ? 8'($urandom) : directed_rows[r].data;
        send_byte(b, directed_rows[r].fin && (k == directed_rows[r].reps - 1),
                  directed_rows[r].typed, directed_rows[r].text);
        idle_sender(pick_gap());
      end
    end

    // Hold the input off until the block has emitted everything so far, so
    // that the next payload starts into a fully drained pipeline.
    idle_sender(1);
    wait_drained();

    // Random payloads. Most are a few bytes long; about one in four is drawn from 40
    // to 120 bytes and cut to what is left of the byte budget. Some payloads run
    // without any sender gaps.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      roll    = $urandom_range(0, 99);
      len     = (roll < 75) ? $urandom_range(1, 12) : $urandom_range(40, 120);
      if (len > RANDOM_BYTES - sent) len = RANDOM_BYTES - sent;
      gaps_on = $urandom_range(0, 9) >= 4;
      for (int k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) b = 8'h00;
        else if (roll < 16) b = 8'hFF;
        else b = 8'($urandom);
        send_byte(b, k == len - 1, 1'b0, "");
        sent++;
        if (gaps_on) idle_sender(pick_gap());
      end
      if ($urandom_range(0, 9) == 0) begin
        idle_sender(1);
        wait_drained();
      end
    end

    // Let every owed character arrive, then watch a little longer for any
    // stray transfer.
    idle_sender(1);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
